/* sv/dcps_pkg.sv */
// ---------------------------------------------------------------------------
// dcps_pkg: shared types and constants
// Command record between the line parser and the command executor, result
// layout and command codes of the decimal command power switch.
// ---------------------------------------------------------------------------
`default_nettype none

package dcps_pkg;

  localparam int NUM_W   = 27;
  localparam int OUT_W   = 48;
  localparam int VOLT_W  = 14;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VTAB  = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // command codes
  localparam logic [NUM_W-1:0] CMD_KEEPALIVE = 27'd66300744;
  localparam logic [NUM_W-1:0] VOLT_LO  = 27'd20000;
  localparam logic [NUM_W-1:0] VOLT_HI  = 27'd29132;
  localparam logic [NUM_W-1:0] DUTY5_LO = 27'd5000;
  localparam logic [NUM_W-1:0] DUTY5_HI = 27'd5255;
  localparam logic [NUM_W-1:0] DUTY6_LO = 27'd6000;
  localparam logic [NUM_W-1:0] DUTY6_HI = 27'd6255;
  localparam logic [NUM_W-1:0] DUTY7_LO = 27'd7000;
  localparam logic [NUM_W-1:0] DUTY7_HI = 27'd7255;

  // switch commands: off code listed, the on code is one higher
  localparam logic [NUM_W-1:0] CMD_DC3_4    = 27'd100;
  localparam logic [NUM_W-1:0] CMD_DC8_9    = 27'd200;
  localparam logic [NUM_W-1:0] CMD_DC10_11  = 27'd210;
  localparam logic [NUM_W-1:0] CMD_USB3_1   = 27'd110;
  localparam logic [NUM_W-1:0] CMD_USB3_2   = 27'd120;
  localparam logic [NUM_W-1:0] CMD_USB3_3   = 27'd130;
  localparam logic [NUM_W-1:0] CMD_USB2_1_3 = 27'd140;
  localparam logic [NUM_W-1:0] CMD_USB2_4_6 = 27'd150;

  localparam logic [VOLT_W-1:0] VOLT_RESET = 14'd50;
  localparam logic [VOLT_W-1:0] VOLT_MAX   = 14'd9132;

  // command status codes
  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_KEEPALIVE = 2'd1,
    ST_UNKNOWN   = 2'd2
  } status_t;

  // one decoded line
  typedef struct packed {
    logic             minus;
    logic [NUM_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/dcps_front.sv */
// ---------------------------------------------------------------------------
// dcps_front: line collector and decimal parser
// Takes one byte per cycle unless the queue is full, reads the line as a
// signed decimal number, hands one command per non-empty line to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dcps_front #(
  parameter int LINE_LIMIT = 80
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [7:0]          s_tdata,
  output logic                cmd_valid,
  input  wire                 cmd_ready,
  output dcps_pkg::cmd_t      cmd
);
  import dcps_pkg::*;

  localparam logic [6:0] LEN_STOP = 7'(LINE_LIMIT - 1);

  typedef enum logic [1:0] {
    PH_BLANKS = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic [6:0]       line_len, len_inc;
  logic             minus, minus_next;
  logic [NUM_W-1:0] number, number_next;
  logic [NUM_W+3:0] prod;
  logic             accept, is_digit, is_blank, is_sign, restart;

  assign s_tready  = cmd_ready;
  assign accept    = s_tvalid && s_tready;
  assign cmd_valid = accept && (s_tdata == CH_LF) && (line_len != 7'd0);
  assign cmd       = '{minus: minus, value: number};

  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
                    (s_tdata == CH_VTAB) || (s_tdata == CH_FF);
  assign is_sign  = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS);
  assign len_inc  = line_len + 7'd1;

  // times-ten accumulate: n*8 + n*2 + digit
  assign prod = {1'b0, number, 3'b000} + {3'b000, number, 1'b0} +
                {27'd0, s_tdata[3:0]};

  // parse one ordinary byte
  always_comb begin
    phase_next  = phase;
    minus_next  = minus;
    number_next = number;
    if (phase == PH_BLANKS) begin
      if (is_sign) begin
        minus_next = (s_tdata == CH_MINUS);
        phase_next = PH_DIGITS;
      end else if (!is_blank) begin
        if (is_digit) begin
          number_next = (prod > {4'd0, NUM_MAX}) ? NUM_MAX : prod[NUM_W-1:0];
          phase_next  = PH_DIGITS;
        end else begin
          phase_next  = PH_DONE;
        end
      end
    end else if (phase == PH_DIGITS) begin
      if (is_digit) begin
        number_next = (prod > {4'd0, NUM_MAX}) ? NUM_MAX : prod[NUM_W-1:0];
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  assign restart = (s_tdata == CH_LF) || (len_inc >= LEN_STOP);

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_BLANKS;
      line_len <= '0;
      minus    <= 1'b0;
      number   <= '0;
    end else if (accept && s_tdata != CH_CR) begin
      if (restart) begin
        phase    <= PH_BLANKS;
        line_len <= '0;
        minus    <= 1'b0;
        number   <= '0;
      end else begin
        phase    <= phase_next;
        line_len <= len_inc;
        minus    <= minus_next;
        number   <= number_next;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dcps_queue.sv */
// ---------------------------------------------------------------------------
// dcps_queue: two-entry command queue
// Decouples the parser from the executor so either may stall alone.
// ---------------------------------------------------------------------------
`default_nettype none

module dcps_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 wr_valid,
  output logic                wr_ready,
  input  dcps_pkg::cmd_t      wr_cmd,
  output logic                rd_valid,
  input  wire                 rd_ready,
  output dcps_pkg::cmd_t      rd_cmd
);
  import dcps_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* sv/dcps_back.sv */
// ---------------------------------------------------------------------------
// dcps_back: command executor
// Decodes one queued command, updates switches, duties and voltage, and
// holds the full state report in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module dcps_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  output logic                cmd_ready,
  input  dcps_pkg::cmd_t      cmd,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [dcps_pkg::OUT_W-1:0] m_tdata
);
  import dcps_pkg::*;

  logic [7:0]        switch_bits, switch_next;
  logic [7:0]        duty [3];
  logic [7:0]        duty_next [3];
  logic [VOLT_W-1:0] volt, volt_next;
  status_t           status;
  logic [NUM_W-1:0]  v;
  logic              bit_hit, bit_on;
  logic [2:0]        bit_sel;
  logic              take;

  assign cmd_ready = !m_tvalid || m_tready;
  assign take      = cmd_valid && cmd_ready;
  assign v         = cmd.value;

  // switch command lookup
  always_comb begin
    bit_hit = 1'b1;
    bit_on  = v[0];
    bit_sel = 3'd0;
    unique case (v)
      CMD_DC3_4,    CMD_DC3_4 + 27'd1:    bit_sel = 3'd0;
      CMD_DC8_9,    CMD_DC8_9 + 27'd1:    bit_sel = 3'd1;
      CMD_DC10_11,  CMD_DC10_11 + 27'd1:  bit_sel = 3'd2;
      CMD_USB3_1,   CMD_USB3_1 + 27'd1:   bit_sel = 3'd3;
      CMD_USB3_2,   CMD_USB3_2 + 27'd1:   bit_sel = 3'd4;
      CMD_USB3_3,   CMD_USB3_3 + 27'd1:   bit_sel = 3'd5;
      CMD_USB2_1_3, CMD_USB2_1_3 + 27'd1: bit_sel = 3'd6;
      CMD_USB2_4_6, CMD_USB2_4_6 + 27'd1: bit_sel = 3'd7;
      default:                            bit_hit = 1'b0;
    endcase
  end

  // command decode and state update
  always_comb begin
    switch_next = switch_bits;
    duty_next   = duty;
    volt_next   = volt;
    status      = ST_APPLIED;
    priority if (cmd.minus) begin
      status = ST_UNKNOWN;
    end else if (v == CMD_KEEPALIVE) begin
      status = ST_KEEPALIVE;
    end else if (bit_hit) begin
      switch_next[bit_sel] = bit_on;
    end else if (v >= VOLT_LO && v <= VOLT_HI) begin
      volt_next = VOLT_W'(v - VOLT_LO);
    end else if (v >= DUTY5_LO && v <= DUTY5_HI) begin
      duty_next[0] = 8'(v - DUTY5_LO);
    end else if (v >= DUTY6_LO && v <= DUTY6_HI) begin
      duty_next[1] = 8'(v - DUTY6_LO);
    end else if (v >= DUTY7_LO && v <= DUTY7_HI) begin
      duty_next[2] = 8'(v - DUTY7_LO);
    end else begin
      status = ST_UNKNOWN;
    end
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      switch_bits <= '0;
      duty[0]     <= '0;
      duty[1]     <= '0;
      duty[2]     <= '0;
      volt        <= VOLT_RESET;
    end else if (take) begin
      m_tvalid    <= 1'b1;
      switch_bits <= switch_next;
      duty        <= duty_next;
      volt        <= volt_next;
    end else if (m_tready) begin
      m_tvalid    <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {status, volt_next, duty_next[2], duty_next[1], duty_next[0],
                  switch_next};
    end
  end

endmodule

`default_nettype wire

/* sv/decimal_command_power_switch.sv */
// ---------------------------------------------------------------------------
// decimal_command_power_switch: serial decimal command power switch
// Parses text lines into numeric commands that drive eight switches, three
// PWM duties and an adjustable voltage, reporting all states per command.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one ASCII byte per request in s_tdata. Carriage
//   returns are ignored; a newline ends the line. Lines of LINE_LIMIT-1
//   bytes are dropped; empty lines give nothing.
//   Output stream m_*: one report per non-empty line, carrying switch
//   states, three duties, voltage in tenths and the command status.
//   Throughput: one byte per cycle while s_tready is high. The parser
//   does one times-ten accumulate per byte; the executor handles one
//   command per cycle unless a report is stalled by m_tready low.
//   Report path: the newline's command is written into the queue, then
//   into the executor's output register, from which m_* offers it.
//   Stall: a two-entry queue sits between parser and executor; s_tready
//   drops only while the queue is full, which happens when m_tready holds
//   low and further newlines arrive.
//   Reset: rst (synchronous) clears the line, all switches and duties, and
//   sets the voltage to 5.0 V.
// ---------------------------------------------------------------------------
`default_nettype none

module decimal_command_power_switch #(
  parameter int LINE_LIMIT = 80
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,  // [7:0] rx_byte
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // [7:0] switch_states, [15:8] duty_five, [23:16] duty_six,
  // [31:24] duty_seven, [45:32] volt_tenths, [47:46] command_status
  output logic [dcps_pkg::OUT_W-1:0]   m_tdata
);
  import dcps_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  dcps_front #(.LINE_LIMIT(LINE_LIMIT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  dcps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_cmd   (queue_cmd)
  );

  dcps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

/* sv/dcps_checker.sv */
// ---------------------------------------------------------------------------
// dcps_checker: port-level checks
// Watches the top-level ports for reset behavior, stall holding and legal
// report contents.
// ---------------------------------------------------------------------------
`default_nettype none

module dcps_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        s_tvalid,
  input wire                        s_tready,
  input wire [7:0]                  s_tdata,
  input wire                        m_tvalid,
  input wire                        m_tready,
  input wire [dcps_pkg::OUT_W-1:0]  m_tdata
);
  import dcps_pkg::*;

  // no report right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("report valid after reset");

  // stalled report holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("report changed under stall");

  // status is one of the three legal codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:46] != 2'd3)
    else $error("illegal command status");

  // voltage never leaves its range
  a_volt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[45:32] <= VOLT_MAX)
    else $error("voltage out of range");

  // a fresh report follows an accepted newline via queue and output register
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tdata == CH_LF, 2))
    else $error("report without an accepted newline");

endmodule

bind decimal_command_power_switch dcps_checker u_dcps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
